// ----- rtl/core/huf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_pkg
// Shared field widths, operation and status codes, and sequencer states for
// the code tree decoder.
// ----------------------------------------------------------------------------
package huf_pkg;

  localparam int SYM_W      = 8;
  localparam int CODE_W     = 16;
  localparam int CODE_IDX_W = $clog2(CODE_W);
  localparam int CODE_LEN_W = 5;
  localparam int STATUS_W   = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DC_EVAL,
    ST_LD_STEP,
    ST_LD_FETCH,
    ST_LD_FULL
  } state_t;

endpackage

// ----- rtl/core/huf_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_ifs
// Valid/ready channel interfaces for decoder requests and decoder results.
// ----------------------------------------------------------------------------
interface huf_in_if;
  import huf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [SYM_W-1:0]      symbol;
  logic [CODE_W-1:0]     code_bits;
  logic [CODE_LEN_W-1:0] code_length;
  logic                  bit_req;

  modport source (
    output valid, operation, symbol, code_bits, code_length, bit_req,
    input  ready
  );
  modport sink (
    input  valid, operation, symbol, code_bits, code_length, bit_req,
    output ready
  );
endinterface

interface huf_out_if;
  import huf_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYM_W-1:0]    symbol_out;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, symbol_out, status,
    input  ready
  );
  modport sink (
    input  valid, symbol_out, status,
    output ready
  );
endinterface

// ----- rtl/core/huffman_tree_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Builds a binary code tree in a node table from load transactions and walks it
// one encoded bit per decode; results are a leaf symbol, a miss or table full.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                        Result
//  --------  ---  ---------------------------------------------  -------------
//  in_chan   in   operation, symbol, code_bits, code_length,     -
//                 bit_req
//  out_chan  out  symbol_out, status                             0 or 1 per in
//
//  Sequence: a decode is accepted, then evaluates one node-table read. A load
//  is accepted, then per code bit either allocates a node or follows an
//  existing link with a node-table read and a fetch step, then stores the
//  symbol. The single node-table read port serves both operations.
//  Reset: control state, the root node and the walk pointer clear at once.
//  The node table needs no clearing pass: nodes are handed out in order by
//  the fill count, and each new node is zeroed in registers and written back.
//  Stalls: the result sits in an output register; a new transaction is taken
//  while it waits, and only a later result waits for that register to drain.
//
module huffman_tree_decoder #(
  parameter int MAX_CODE_LEN = 16,
  parameter int NODE_COUNT   = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  huf_in_if.sink    in_chan,
  huf_out_if.source out_chan
);
  import huf_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int ENT_W = 2 * IDX_W + SYM_W;

  // Sequencer and control
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  nodes_used_r, nodes_used_nxt;

  // Root node lives in flops so reset clears it; children live in the RAM
  logic [IDX_W-1:0]  root_left_r, root_left_nxt;
  logic [IDX_W-1:0]  root_right_r, root_right_nxt;
  logic [SYM_W-1:0]  root_value_r, root_value_nxt;

  // Decode walk position and a copy of its child links
  logic [IDX_W-1:0]  walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]  walk_left_r, walk_left_nxt;
  logic [IDX_W-1:0]  walk_right_r, walk_right_nxt;
  logic [IDX_W-1:0]  next_idx_r, next_idx_nxt;

  // Load walk: current node held in registers until written back
  logic [IDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic [IDX_W-1:0]  cur_left_r, cur_left_nxt;
  logic [IDX_W-1:0]  cur_right_r, cur_right_nxt;
  logic [SYM_W-1:0]  cur_value_r, cur_value_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_sym_r, out_sym_nxt;
  status_t           out_status_r, out_status_nxt;

  // Node table access
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_left, rd_right;
  logic [SYM_W-1:0]  rd_value;
  logic              wb_en;
  logic [IDX_W-1:0]  wb_idx, wb_left, wb_right;
  logic [SYM_W-1:0]  wb_value;

  // Helpers
  logic              out_free;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  bit_pos;
  logic              ld_bit;
  logic [IDX_W-1:0]  ld_link;
  logic [IDX_W-1:0]  dc_next;
  logic              dc_leaf;
  logic              emit;
  logic [SYM_W-1:0]  emit_sym;
  status_t           emit_stat;

  assign rd_left  = rd_data[ENT_W-1 -: IDX_W];
  assign rd_right = rd_data[IDX_W+SYM_W-1 -: IDX_W];
  assign rd_value = rd_data[SYM_W-1:0];

  huf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (wb_en && (wb_idx != '0)),
    .waddr (wb_idx),
    .wdata ({wb_left, wb_right, wb_value}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.symbol_out = out_sym_r;
  assign out_chan.status     = out_status_r;

  assign out_free = !out_valid_r || out_chan.ready;

  // Clamp long codes to the supported length
  assign len_sat = (int'(in_chan.code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                              : LEN_W'(in_chan.code_length);

  // Next code bit, most significant used bit first; positions past the field read 0
  assign bit_pos = LEN_W'(rem_r - LEN_W'(1));
  assign ld_bit  = (int'(bit_pos) < CODE_W) ? code_r[CODE_IDX_W'(bit_pos)] : 1'b0;
  assign ld_link = ld_bit ? cur_right_r : cur_left_r;

  assign dc_next = in_chan.bit_req ? walk_right_r : walk_left_r;
  assign dc_leaf = (rd_left == '0) && (rd_right == '0);

  always_comb begin
    state_nxt      = state_r;
    nodes_used_nxt = nodes_used_r;
    root_left_nxt  = root_left_r;
    root_right_nxt = root_right_r;
    root_value_nxt = root_value_r;
    walk_idx_nxt   = walk_idx_r;
    walk_left_nxt  = walk_left_r;
    walk_right_nxt = walk_right_r;
    next_idx_nxt   = next_idx_r;
    cur_idx_nxt    = cur_idx_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    cur_value_nxt  = cur_value_r;
    rem_nxt        = rem_r;
    code_nxt       = code_r;
    sym_nxt        = sym_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wb_en          = 1'b0;
    wb_idx         = cur_idx_r;
    wb_left        = cur_left_r;
    wb_right       = cur_right_r;
    wb_value       = cur_value_r;
    emit           = 1'b0;
    emit_sym       = '0;
    emit_stat      = STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.operation == OP_DECODE) begin
            // Fetch the child now; its links and value are checked next cycle
            rd_en        = 1'b1;
            rd_addr      = dc_next;
            next_idx_nxt = dc_next;
            state_nxt    = ST_DC_EVAL;
          end else begin
            cur_idx_nxt   = '0;
            cur_left_nxt  = root_left_r;
            cur_right_nxt = root_right_r;
            cur_value_nxt = root_value_r;
            rem_nxt       = len_sat;
            code_nxt      = in_chan.code_bits;
            sym_nxt       = in_chan.symbol;
            state_nxt     = ST_LD_STEP;
          end
        end
      end

      ST_DC_EVAL: begin
        if ((next_idx_r == '0) || dc_leaf) begin
          // Missing branch or leaf: report and return to the root
          if (out_free) begin
            emit           = 1'b1;
            emit_sym       = (next_idx_r == '0) ? '0 : rd_value;
            emit_stat      = (next_idx_r == '0) ? STAT_MISS : STAT_OK;
            walk_idx_nxt   = '0;
            walk_left_nxt  = root_left_r;
            walk_right_nxt = root_right_r;
            state_nxt      = ST_IDLE;
          end
        end else begin
          walk_idx_nxt   = next_idx_r;
          walk_left_nxt  = rd_left;
          walk_right_nxt = rd_right;
          state_nxt      = ST_IDLE;
        end
      end

      ST_LD_STEP: begin
        wb_en = 1'b1;
        if (rem_r == '0) begin
          // End of code: store the symbol in the current node
          wb_value  = sym_r;
          state_nxt = ST_IDLE;
        end else if (ld_link != '0) begin
          rd_en       = 1'b1;
          rd_addr     = ld_link;
          cur_idx_nxt = ld_link;
          rem_nxt     = LEN_W'(rem_r - LEN_W'(1));
          state_nxt   = ST_LD_FETCH;
        end else if (nodes_used_r == CNT_W'(NODE_COUNT)) begin
          state_nxt = ST_LD_FULL;
        end else begin
          // Allocate the next free node and link it from the current one
          if (ld_bit) begin
            wb_right = nodes_used_r[IDX_W-1:0];
          end else begin
            wb_left  = nodes_used_r[IDX_W-1:0];
          end
          cur_idx_nxt    = nodes_used_r[IDX_W-1:0];
          cur_left_nxt   = '0;
          cur_right_nxt  = '0;
          cur_value_nxt  = '0;
          nodes_used_nxt = CNT_W'(nodes_used_r + CNT_W'(1));
          rem_nxt        = LEN_W'(rem_r - LEN_W'(1));
        end
      end

      ST_LD_FETCH: begin
        cur_left_nxt  = rd_left;
        cur_right_nxt = rd_right;
        cur_value_nxt = rd_value;
        state_nxt     = ST_LD_STEP;
      end

      ST_LD_FULL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_stat = STAT_FULL;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Route root writes to flops and keep the walk's link copy coherent
    if (wb_en && (wb_idx == '0)) begin
      root_left_nxt  = wb_left;
      root_right_nxt = wb_right;
      root_value_nxt = wb_value;
    end
    if (wb_en && (wb_idx == walk_idx_r)) begin
      walk_left_nxt  = wb_left;
      walk_right_nxt = wb_right;
    end

    out_valid_nxt  = emit || (out_valid_r && !out_chan.ready);
    out_sym_nxt    = emit ? emit_sym : out_sym_r;
    out_status_nxt = emit ? emit_stat : out_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nodes_used_r <= CNT_W'(1);
      root_left_r  <= '0;
      root_right_r <= '0;
      root_value_r <= '0;
      walk_idx_r   <= '0;
      walk_left_r  <= '0;
      walk_right_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      root_left_r  <= root_left_nxt;
      root_right_r <= root_right_nxt;
      root_value_r <= root_value_nxt;
      walk_idx_r   <= walk_idx_nxt;
      walk_left_r  <= walk_left_nxt;
      walk_right_r <= walk_right_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    next_idx_r   <= next_idx_nxt;
    cur_idx_r    <= cur_idx_nxt;
    cur_left_r   <= cur_left_nxt;
    cur_right_r  <= cur_right_nxt;
    cur_value_r  <= cur_value_nxt;
    rem_r        <= rem_nxt;
    code_r       <= code_nxt;
    sym_r        <= sym_nxt;
    out_sym_r    <= out_sym_nxt;
    out_status_r <= out_status_nxt;
  end

  // Fill count stays within the table and never drops below the root
  a_nodes_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r >= CNT_W'(1)) && (nodes_used_r <= CNT_W'(NODE_COUNT)))
    else $error("node fill count out of range");

  // The walk only ever points at an allocated node
  a_walk_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(walk_idx_r) < nodes_used_r)
    else $error("walk pointer beyond allocated nodes");

  // Error results carry a zero symbol
  a_err_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_sym_r == '0))
    else $error("error result with nonzero symbol");

  // A new node is only handed out during a load step
  a_alloc_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (nodes_used_r != $past(nodes_used_r)) |-> ($past(state_r) == ST_LD_STEP))
    else $error("node allocated outside a load step");

endmodule

// ----- rtl/core/huf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module huf_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/tb_huffman_tree_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_decoder
// Self-checking bench for the code tree decoder. A short directed table
// builds a small tree and probes its corners. Random traffic then loads
// prefix-free codebooks under free subtrees and streams their codewords
// bit by bit, with some noise and broken codewords mixed in. At the end a
// burst of long codes runs the node table out of nodes. Every result is
// checked against a tree model that the bench keeps on its own.
// ----------------------------------------------------------------------------
module tb_huffman_tree_decoder;
  import huf_pkg::*;

  localparam int MAX_CODE_LEN = 16;
  localparam int NODE_COUNT   = 512;
  localparam int DIR_ROWS     = 25;
  // Time for the longest load to finish, with margin to spare after the last one.
  localparam int SETTLE_CYCLES = 2 * MAX_CODE_LEN + 8;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int QUIET_LIMIT   = 2000;
  localparam int CB_MAX        = 24;
  localparam int CB_DEPTH      = 7;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    status_t          st;
  } decoded_t;

  // One row of the directed table; chk marks a result typed in by hand.
  typedef struct packed {
    op_t                   op;
    logic [SYM_W-1:0]      sym;
    logic [CODE_W-1:0]     code;
    logic [CODE_LEN_W-1:0] len;
    logic                  bit_in;
    logic                  chk;
    logic [SYM_W-1:0]      exp_sym;
    status_t               exp_st;
  } dir_row_t;

  logic clk;
  logic rst_n;

  huf_in_if  in_if ();
  huf_out_if out_if ();

  huffman_tree_decoder #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NODE_COUNT   (NODE_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // --------------------------------------------------------------------------
  // Tree model: child links (0 is null, the root is never a child), node
  // values, fill count and the decode walk position.
  // --------------------------------------------------------------------------
  logic [9:0]       link_left  [NODE_COUNT];
  logic [9:0]       link_right [NODE_COUNT];
  logic [SYM_W-1:0] node_val   [NODE_COUNT];
  int               nodes_used;
  int               walk_at;

  decoded_t pending_symbols[$];

  // Directed rows may override the modeled result with a hand-typed one.
  logic             row_typed;
  logic [SYM_W-1:0] row_sym;
  status_t          row_st;

  int send_idle_pct;
  int recv_idle_pct;
  int item_count;
  int mismatches;
  int quiet_cycles;

  dir_row_t dir_rows [DIR_ROWS];

  // Current codebook: full codes including the subtree prefix.
  logic [CODE_W-1:0] cb_code [CB_MAX];
  int                cb_len  [CB_MAX];
  logic [SYM_W-1:0]  cb_sym  [CB_MAX];
  int                cb_n;

  // Apply one request to the tree model; returns 1 when it yields a result.
  function automatic bit tree_walk_step(input op_t op, input logic [SYM_W-1:0] sym,
                                        input logic [CODE_W-1:0] code,
                                        input logic [CODE_LEN_W-1:0] len,
                                        input logic bit_in, output decoded_t res);
    int   node;
    int   nxt;
    int   depth;
    int   i;
    logic dir;
    res.sym = '0;
    res.st  = STAT_OK;
    if (op == OP_LOAD) begin
      depth = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
      node  = 0;
      for (i = depth - 1; i >= 0; i--) begin
        dir = code[i];
        nxt = dir ? link_right[node] : link_left[node];
        if (nxt == 0) begin
          // Out of nodes: stop here, keep what was allocated on the way.
          if (nodes_used >= NODE_COUNT) begin
            res.st = STAT_FULL;
            return 1'b1;
          end
          link_left[nodes_used]  = '0;
          link_right[nodes_used] = '0;
          node_val[nodes_used]   = '0;
          nxt = nodes_used;
          if (dir) begin
            link_right[node] = nxt[9:0];
          end else begin
            link_left[node] = nxt[9:0];
          end
          nodes_used++;
        end
        node = nxt;
      end
      node_val[node] = sym;
      return 1'b0;
    end
    nxt = bit_in ? link_right[walk_at] : link_left[walk_at];
    if (nxt == 0) begin
      walk_at = 0;
      res.st  = STAT_MISS;
      return 1'b1;
    end
    if (link_left[nxt] == 0 && link_right[nxt] == 0) begin
      walk_at = 0;
      res.sym = node_val[nxt];
      return 1'b1;
    end
    walk_at = nxt;
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Clock and receiver back-pressure. The receiver stalls at random per cycle,
  // changing ready only at the falling edge.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: check accepted results first, then model the accepted request,
  // all on the rising edge. Also run the watchdog here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t want;
    decoded_t got_model;
    logic     in_acc;
    logic     out_acc;
    if (rst_n) begin
      in_acc  = in_if.valid && in_if.ready;
      out_acc = out_if.valid && out_if.ready;
      if (out_acc) begin
        if (pending_symbols.size() == 0) begin
          flag_mismatch($sformatf("unexpected result symbol=%02h status=%0d",
                                  out_if.symbol_out, out_if.status));
        end else begin
          want = pending_symbols.pop_front();
          if (out_if.status !== want.st)
            flag_mismatch($sformatf("status %0d, want %0d", out_if.status, want.st));
          if (out_if.symbol_out !== want.sym)
            flag_mismatch($sformatf("symbol_out %02h, want %02h",
                                    out_if.symbol_out, want.sym));
        end
      end
      if (in_acc) begin
        // Always advance the model; a typed-in row replaces only its result.
        if (tree_walk_step(op_t'(in_if.operation), in_if.symbol, in_if.code_bits,
                           in_if.code_length, in_if.bit_req, got_model)) begin
          if (row_typed) begin
            want.sym = row_sym;
            want.st  = row_st;
            pending_symbols.push_back(want);
          end else begin
            pending_symbols.push_back(got_model);
          end
        end
      end
      if (in_acc || out_acc) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_huffman_tree_decoder NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // transaction. Valid stays high across back-to-back requests and gets one
  // assignment per edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input op_t op, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] code,
                              input logic [CODE_LEN_W-1:0] len, input logic bit_in);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.symbol      <= sym;
    in_if.code_bits   <= code;
    in_if.code_length <= len;
    in_if.bit_req     <= bit_in;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  // Decode request with junk in the fields a decode ignores.
  task automatic send_bit(input logic bit_in);
    send_request(OP_DECODE, SYM_W'($urandom_range(0, 255)),
                 CODE_W'($urandom_range(0, 65535)),
                 CODE_LEN_W'($urandom_range(0, 31)), bit_in);
  endtask

  // Drop valid, then hold the sender off until every pending result has drained.
  task automatic wait_for_results;
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_symbols.size() != 0) @(negedge clk);
  endtask

  // Build a random complete prefix code under a free subtree and load it.
  task automatic load_codebook(input logic [CODE_W-1:0] prefix, input int plen);
    int target;
    int k;
    target = $urandom_range(6, 20);
    cb_n       = 1;
    cb_code[0] = '0;
    cb_len[0]  = 0;
    // Split random leaves until the codebook reaches its size.
    while (cb_n < target) begin
      k = $urandom_range(0, cb_n - 1);
      if (cb_len[k] < CB_DEPTH) begin
        cb_code[cb_n] = (cb_code[k] << 1) | 1'b1;
        cb_len[cb_n]  = cb_len[k] + 1;
        cb_code[k]    = cb_code[k] << 1;
        cb_len[k]     = cb_len[k] + 1;
        cb_n++;
      end
    end
    for (k = 0; k < cb_n; k++) begin
      cb_code[k] = (prefix << cb_len[k]) | cb_code[k];
      cb_len[k]  = cb_len[k] + plen;
      cb_sym[k]  = SYM_W'($urandom_range(0, 255));
      send_request(OP_LOAD, cb_sym[k], cb_code[k], CODE_LEN_W'(cb_len[k]),
                   1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly whole codewords with random content; the rest is noise bits,
  // symbol reloads, random loads and codewords cut short.
  task automatic run_traffic(input int goal, input int noise_load_pct);
    int start;
    int pick;
    int k;
    int nbits;
    int i;
    start = item_count;
    while (item_count - start < goal) begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, cb_n - 1);
      if (pick < 74) begin
        for (i = cb_len[k] - 1; i >= 0; i--) send_bit(cb_code[k][i]);
      end else if (pick < 84) begin
        send_bit(1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        cb_sym[k] = SYM_W'($urandom_range(0, 255));
        send_request(OP_LOAD, cb_sym[k], cb_code[k], CODE_LEN_W'(cb_len[k]),
                     1'($urandom_range(0, 1)));
      end else if (pick < 92 + noise_load_pct) begin
        send_request(OP_LOAD, SYM_W'($urandom_range(0, 255)),
                     CODE_W'($urandom_range(0, 65535)),
                     CODE_LEN_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else begin
        // Broken codeword: stop partway and leave the walk mid-tree.
        nbits = $urandom_range(1, cb_len[k] - 1);
        for (i = cb_len[k] - 1; i >= cb_len[k] - nbits; i--) send_bit(cb_code[k][i]);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_LOAD;
    in_if.symbol      = '0;
    in_if.code_bits   = '0;
    in_if.code_length = '0;
    in_if.bit_req     = 1'b0;
    rst_n             = 1'b0;
    row_typed         = 1'b0;
    row_sym           = '0;
    row_st            = STAT_OK;
    send_idle_pct     = 31;
    recv_idle_pct     = 45;
    item_count        = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    cb_n              = 0;
    for (r = 0; r < NODE_COUNT; r++) begin
      link_left[r]  = '0;
      link_right[r] = '0;
      node_val[r]   = '0;
    end
    nodes_used = 1;
    walk_at    = 0;

    // Directed table. Hand-typed results: empty tree misses, first leaves,
    // a leaf reached across a load, a missing branch mid-walk.
    dir_rows = '{
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, STAT_MISS},
      '{OP_DECODE, 8'hFF, 16'hFFFF, 5'd31, 1'b1, 1'b1, 8'h00, STAT_MISS},
      '{OP_LOAD,   8'h41, 16'h0000, 5'd1,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_LOAD,   8'h42, 16'h0002, 5'd2,  1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_LOAD,   8'hFF, 16'h0003, 5'd2,  1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h41, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h42, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b1, 8'hFF, STAT_OK},
      // Full-length all-ones code, then an over-long all-zeros code that
      // saturates, then a zero-length code that lands in the root.
      '{OP_LOAD,   8'h00, 16'hFFFF, 5'd16, 1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_LOAD,   8'h80, 16'h0000, 5'd31, 1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_LOAD,   8'h5A, 16'h1234, 5'd0,  1'b0, 1'b0, 8'h00, STAT_OK},
      // Load in the middle of a walk must not move the walk.
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_LOAD,   8'h33, 16'h0006, 5'd4,  1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h42, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h00, STAT_MISS},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b0, 1'b1, 8'h33, STAT_OK},
      // Turn a leaf into an inner node, then step into its parent.
      '{OP_LOAD,   8'hA5, 16'h8000, 5'd16, 1'b1, 1'b0, 8'h00, STAT_OK},
      '{OP_DECODE, 8'h00, 16'h0000, 5'd0,  1'b1, 1'b0, 8'h00, STAT_OK}
    };

    // Synchronous reset, released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      row_typed = dir_rows[r].chk;
      row_sym   = dir_rows[r].exp_sym;
      row_st    = dir_rows[r].exp_st;
      send_request(dir_rows[r].op, dir_rows[r].sym, dir_rows[r].code,
                   dir_rows[r].len, dir_rows[r].bit_in);
    end
    row_typed = 1'b0;
    wait_for_results();

    // Sender idles often, receiver more so; codebook under prefix 010.
    load_codebook(16'h0002, 3);
    wait_for_results();
    run_traffic(580, 2);
    wait_for_results();

    // Swap the idling; codebook under prefix 0111.
    send_idle_pct = 45;
    recv_idle_pct = 31;
    load_codebook(16'h0007, 4);
    run_traffic(580, 2);
    wait_for_results();

    // Full rate both ways; codebook under prefix 101.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_codebook(16'h0005, 3);
    run_traffic(400, 2);

    // Run the node table dry with long random codes, then keep going.
    while (nodes_used < NODE_COUNT) begin
      send_request(OP_LOAD, SYM_W'($urandom_range(0, 255)),
                   CODE_W'($urandom_range(0, 65535)),
                   CODE_LEN_W'($urandom_range(10, 31)), 1'($urandom_range(0, 1)));
    end
    for (r = 0; r < 12; r++) begin
      send_request(OP_LOAD, SYM_W'($urandom_range(0, 255)),
                   CODE_W'($urandom_range(0, 65535)),
                   CODE_LEN_W'($urandom_range(12, 16)), 1'($urandom_range(0, 1)));
    end
    run_traffic(150, 5);

    // Drain, then give any trailing load time to finish before judging.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_huffman_tree_decoder OK");
    end else begin
      $display("tb_huffman_tree_decoder NOT OK");
    end
    $finish;
  end

endmodule
